>>> sv/atan2_phi_lut_core_macros.svh
// Assertion macros used by the checker file of the angle lookup core.
// Depends on a2phi_pkg; include by bare file name.
`ifndef ATAN2_PHI_LUT_CORE_MACROS_SVH
`define ATAN2_PHI_LUT_CORE_MACROS_SVH

// Implication checked on every clock edge, disabled while reset is high.
`define A2PHI_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Cause at one edge, effect a full pipeline latency later.
`define A2PHI_AFTER(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (cause) |-> ##(a2phi_pkg::PIPE_LATENCY) (effect)) \
      else $error(msg);

`endif

>>> sv/a2phi_pkg.sv
// Package of the angle lookup core: widths, beat structs, state type and
// the first-quadrant arctan table built at elaboration. Depends on nothing.
package a2phi_pkg;

   localparam int KEEP_BITS = 5;
   localparam int PHI_BITS  = 10;
   localparam int MAG_BITS  = 12;

   localparam int IN_W      = MAG_BITS + 1;
   localparam int MAG_W     = MAG_BITS + 1;
   localparam int LEAD_W    = $clog2(MAG_W);
   localparam int ADDR_W    = 2 * KEEP_BITS;
   localparam int TABLE_LEN = 1 << ADDR_W;
   localparam int CODE_W    = PHI_BITS - 1;
   localparam int RED_MASK  = (1 << KEEP_BITS) - 1;
   localparam int PHI_COUNT = 1 << PHI_BITS;
   localparam int PHI_HALF  = PHI_COUNT / 2;
   localparam int PHI_QUART = PHI_COUNT / 4;
   localparam int PHI_EIGHT = PHI_COUNT / 8;

   // Accept to result strobe, in clock edges.
   localparam int PIPE_LATENCY = 5;

   localparam real TWO_PI = 2.0 * 3.14159265358979323846;

   typedef logic [CODE_W-1:0] rom_type [TABLE_LEN];

   typedef enum logic {
      ST_FILL,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic              valid;
      logic              neg_x;
      logic              neg_y;
      logic [ADDR_W-1:0] addr;
   } lookup_type;

   typedef struct packed {
      logic valid;
      logic neg_x;
      logic neg_y;
   } sign_type;

   // Rounded first-quadrant angle codes; the row is y, the column x.
   function automatic rom_type build_rom();
      rom_type rom;
      real     ang;
      int      code;
      for (int ay = 0; ay <= RED_MASK; ay++) begin
         for (int ax = 0; ax <= RED_MASK; ax++) begin
            if (ay == 0) begin
               code = 0;
            end else if (ax == 0) begin
               code = PHI_QUART;
            end else if (ax == ay) begin
               code = PHI_EIGHT;
            end else begin
               ang  = $atan2(real'(ay), real'(ax));
               code = int'($floor(ang / TWO_PI * real'(PHI_COUNT) + 0.5));
            end
            rom[ax + (ay << KEEP_BITS)] = CODE_W'(code);
         end
      end
      return rom;
   endfunction

   localparam rom_type ANGLE_ROM = build_rom();

endpackage

>>> sv/a2phi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module a2phi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/a2phi_reduce.sv
// Three-stage front end: magnitudes and signs, leading-one shift, then the
// shifted and clamped table address. Depends on a2phi_pkg.
module a2phi_reduce (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [a2phi_pkg::IN_W-1:0]  comp_x,
   input  logic signed [a2phi_pkg::IN_W-1:0]  comp_y,
   output a2phi_pkg::lookup_type              lookup
);

   // Stage 1: magnitudes.
   logic                            v1_ff, negx1_ff, negy1_ff;
   logic [a2phi_pkg::MAG_W-1:0]     magx1_ff, magy1_ff;
   logic [a2phi_pkg::MAG_W-1:0]     magx1_in, magy1_in;

   // Stage 2: shift amount.
   logic                            v2_ff, negx2_ff, negy2_ff;
   logic [a2phi_pkg::MAG_W-1:0]     magx2_ff, magy2_ff;
   logic [a2phi_pkg::LEAD_W-1:0]    sh2_ff, sh2_in;
   logic [a2phi_pkg::MAG_W-1:0]     big;
   logic [a2phi_pkg::LEAD_W-1:0]    lead;
   logic                            found;

   // Stage 3: address.
   a2phi_pkg::lookup_type           lookup_ff, lookup_in;
   logic [a2phi_pkg::MAG_W-1:0]     rx_full, ry_full;
   logic [a2phi_pkg::KEEP_BITS-1:0] rx, ry;

   // The most negative input has a magnitude one beyond the positive range,
   // which still fits the unsigned magnitude width.
   always_comb begin
      magx1_in = comp_x[a2phi_pkg::IN_W-1] ? (~comp_x) + 1'b1 : comp_x;
      magy1_in = comp_y[a2phi_pkg::IN_W-1] ? (~comp_y) + 1'b1 : comp_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      negx1_ff <= comp_x[a2phi_pkg::IN_W-1];
      negy1_ff <= comp_y[a2phi_pkg::IN_W-1];
      magx1_ff <= magx1_in;
      magy1_ff <= magy1_in;
   end

   always_comb begin
      big   = (magx1_ff > magy1_ff) ? magx1_ff : magy1_ff;
      lead  = '0;
      found = 1'b0;
      for (int b = 0; b < a2phi_pkg::MAG_W; b++) begin
         if (big[b]) begin
            lead  = a2phi_pkg::LEAD_W'(b);
            found = 1'b1;
         end
      end
      sh2_in = '0;
      if (found && int'(lead) >= a2phi_pkg::KEEP_BITS - 1) begin
         sh2_in = a2phi_pkg::LEAD_W'(int'(lead) - (a2phi_pkg::KEEP_BITS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      negx2_ff <= negx1_ff;
      negy2_ff <= negy1_ff;
      magx2_ff <= magx1_ff;
      magy2_ff <= magy1_ff;
      sh2_ff   <= sh2_in;
   end

   always_comb begin
      rx_full = magx2_ff >> sh2_ff;
      ry_full = magy2_ff >> sh2_ff;
      if (rx_full > a2phi_pkg::MAG_W'(a2phi_pkg::RED_MASK)) begin
         rx = a2phi_pkg::KEEP_BITS'(a2phi_pkg::RED_MASK);
      end else begin
         rx = rx_full[a2phi_pkg::KEEP_BITS-1:0];
      end
      if (ry_full > a2phi_pkg::MAG_W'(a2phi_pkg::RED_MASK)) begin
         ry = a2phi_pkg::KEEP_BITS'(a2phi_pkg::RED_MASK);
      end else begin
         ry = ry_full[a2phi_pkg::KEEP_BITS-1:0];
      end
      lookup_in.valid = v2_ff;
      lookup_in.neg_x = negx2_ff;
      lookup_in.neg_y = negy2_ff;
      lookup_in.addr  = {ry, rx};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_ff.valid <= 1'b0;
      end else begin
         lookup_ff.valid <= lookup_in.valid;
      end
      lookup_ff.neg_x <= lookup_in.neg_x;
      lookup_ff.neg_y <= lookup_in.neg_y;
      lookup_ff.addr  <= lookup_in.addr;
   end

   assign lookup = lookup_ff;

endmodule

>>> sv/a2phi_fold.sv
// Output stage: folds the first-quadrant code into the full circle by the
// signs of the components and registers the result. Depends on a2phi_pkg.
module a2phi_fold (
   input  logic                            clock,
   input  logic                            reset,
   input  a2phi_pkg::sign_type             tag,
   input  logic [a2phi_pkg::CODE_W-1:0]    code,
   output logic                            out_valid,
   output logic [a2phi_pkg::PHI_BITS-1:0]  phi_word
);

   logic                            valid_ff;
   logic [a2phi_pkg::PHI_BITS-1:0]  phi_ff, phi_in;
   logic [a2phi_pkg::PHI_BITS-1:0]  code_ext;

   // Sums wrap at the word width, which gives the modulo of the full circle.
   always_comb begin
      code_ext = a2phi_pkg::PHI_BITS'(code);
      if (!tag.neg_x && !tag.neg_y) begin
         phi_in = code_ext;
      end else if (tag.neg_x && !tag.neg_y) begin
         phi_in = a2phi_pkg::PHI_BITS'(a2phi_pkg::PHI_HALF) - code_ext;
      end else if (tag.neg_x && tag.neg_y) begin
         phi_in = a2phi_pkg::PHI_BITS'(a2phi_pkg::PHI_HALF) + code_ext;
      end else begin
         phi_in = '0 - code_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tag.valid;
      end
      phi_ff <= phi_in;
   end

   assign out_valid = valid_ff;
   assign phi_word  = phi_ff;

endmodule

>>> sv/atan2_phi_lut_core.sv
// Top level of the full-circle angle lookup core.
// Depends on a2phi_pkg, a2phi_reduce, a2phi_ram and a2phi_fold.
//
//   Channel   Ports                              Handshake
//   request   req_comp_x, req_comp_y             beat taken when start && !busy
//   response  rsp_phi_word                       one-cycle strobe rsp_valid
//
// One beat may enter on every clock while busy is low; on its way to the
// strobe it passes the magnitude, shift, address, table read and fold
// registers.
// After reset the angle table RAM is loaded from the built-in codes, one
// entry a cycle, so busy stays high until all 1024 entries are written and then stays low.
// The receiver cannot stall, so the pipeline never holds; each beat moves on
// one stage per clock.
module atan2_phi_lut_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [a2phi_pkg::IN_W-1:0]  req_comp_x,
   input  logic signed [a2phi_pkg::IN_W-1:0]  req_comp_y,
   output logic                               rsp_valid,
   output logic [a2phi_pkg::PHI_BITS-1:0]     rsp_phi_word
);

   a2phi_pkg::state_type                state_ff, state_in;
   logic [a2phi_pkg::ADDR_W-1:0]        fill_idx_ff, fill_idx_in;
   logic                                fill_we;
   logic                                accept;
   a2phi_pkg::lookup_type               lookup;
   a2phi_pkg::sign_type                 tag_ff, tag_in;
   logic [a2phi_pkg::CODE_W-1:0]        code;

   // Next state.
   always_comb begin
      state_in    = state_ff;
      fill_idx_in = fill_idx_ff;
      case (state_ff)
         a2phi_pkg::ST_FILL: begin
            fill_idx_in = fill_idx_ff + 1'b1;
            if (fill_idx_ff == '1) begin
               state_in = a2phi_pkg::ST_RUN;
            end
         end
         a2phi_pkg::ST_RUN: begin
            state_in = a2phi_pkg::ST_RUN;
         end
         default: begin
            state_in = a2phi_pkg::ST_FILL;
         end
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      case (state_ff)
         a2phi_pkg::ST_FILL: begin
            busy    = 1'b1;
            fill_we = 1'b1;
         end
         a2phi_pkg::ST_RUN: begin
            busy    = 1'b0;
            fill_we = 1'b0;
         end
         default: begin
            busy    = 1'b1;
            fill_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= a2phi_pkg::ST_FILL;
         fill_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         fill_idx_ff <= fill_idx_in;
      end
   end

   assign accept = start && !busy;

   a2phi_reduce u_reduce (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .comp_x   (req_comp_x),
      .comp_y   (req_comp_y),
      .lookup   (lookup)
   );

   a2phi_ram #(
      .WIDTH (a2phi_pkg::CODE_W),
      .DEPTH (a2phi_pkg::TABLE_LEN)
   ) u_table (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_idx_ff),
      .wr_data (a2phi_pkg::ANGLE_ROM[fill_idx_ff]),
      .rd_addr (lookup.addr),
      .rd_data (code)
   );

   // Signs travel alongside the table read.
   always_comb begin
      tag_in.valid = lookup.valid;
      tag_in.neg_x = lookup.neg_x;
      tag_in.neg_y = lookup.neg_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in.valid;
      end
      tag_ff.neg_x <= tag_in.neg_x;
      tag_ff.neg_y <= tag_in.neg_y;
   end

   a2phi_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .tag       (tag_ff),
      .code      (code),
      .out_valid (rsp_valid),
      .phi_word  (rsp_phi_word)
   );

endmodule

>>> sv/a2phi_checker.sv
// Port-level checker for the angle lookup core, bound to the top level.
// Depends on a2phi_pkg and atan2_phi_lut_core_macros.svh.
`include "atan2_phi_lut_core_macros.svh"

module a2phi_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic signed [a2phi_pkg::IN_W-1:0]  req_comp_x,
   input  logic signed [a2phi_pkg::IN_W-1:0]  req_comp_y,
   input  logic                               rsp_valid,
   input  logic [a2phi_pkg::PHI_BITS-1:0]     rsp_phi_word
);

   `A2PHI_AFTER(a_beat_answered, clock, reset, start && !busy, rsp_valid, "beat lost")
   `A2PHI_AFTER(a_no_extra_beat, clock, reset, !(start && !busy), !rsp_valid, "beat invented")
   `A2PHI_AFTER(a_origin_zero, clock, reset, start && !busy && req_comp_x == '0 && req_comp_y == '0, rsp_phi_word == '0, "origin not mapped to zero")
   `A2PHI_CHECK(a_busy_stays_low, clock, reset, !busy |=> !busy, "busy rose after table load")

endmodule

bind atan2_phi_lut_core a2phi_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_comp_x   (req_comp_x),
   .req_comp_y   (req_comp_y),
   .rsp_valid    (rsp_valid),
   .rsp_phi_word (rsp_phi_word)
);
